@@ sv/assert_macros.svh @@
// assertion macros for the minifloat unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mfau_pkg.sv @@
// shared types and constants for the minifloat add / multiply unit
package mfau_pkg;
	localparam int EXP_BITS  = 5;
	localparam int FRAC_BITS = 6;
	localparam int GUARD     = 3;
	localparam int WORD_BITS = 1 + EXP_BITS + FRAC_BITS;
	localparam int SIGN_POS  = EXP_BITS + FRAC_BITS;
	localparam int BIAS      = (1 << (EXP_BITS - 1)) - 1;
	localparam int EXP_MAX   = (1 << EXP_BITS) - 2;
	localparam int MANT_BITS = FRAC_BITS + 1;
	localparam int SUM_BITS  = MANT_BITS + GUARD + 1;
	localparam int EW        = EXP_BITS + 3;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_MUL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_NORMAL    = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] result;
		status_t              status;
	} res_t;
endpackage

@@ sv/mfau_core.sv @@
// combinational add / multiply datapath for one request
module mfau_core
	import mfau_pkg::*;
(
	input  op_t                  opcode,
	input  logic [WORD_BITS-1:0] operand_a,
	input  logic [WORD_BITS-1:0] operand_b,
	output res_t                 res
);

	logic [EXP_BITS-1:0]    ea, eb;
	logic                   sa, sb;
	logic [SIGN_POS-1:0]    maga, magb, big, sml;
	logic                   sbig;
	logic [2*MANT_BITS-1:0] prod;
	logic [EXP_BITS-1:0]    ebig, esmall, d;
	logic [SUM_BITS-1:0]    ma, mb, mbs, sum;
	logic [3:0]             p;
	logic signed [EW-1:0]   e_mul, e_add;
	logic [FRAC_BITS-1:0]   f_mul, f_add;

	function automatic res_t pack_res(logic s, logic signed [EW-1:0] e,
			logic [FRAC_BITS-1:0] f);
		res_t r;
		if (e > EW'(EXP_MAX)) begin
			r.result = '1;
			r.status = ST_OVERFLOW;
		end else if (e < EW'(1)) begin
			r.result = '0;
			r.status = ST_UNDERFLOW;
		end else begin
			r.result = {s, e[EXP_BITS-1:0], f};
			r.status = ST_NORMAL;
		end
		return r;
	endfunction

	always_comb begin
		ea = operand_a[SIGN_POS-1:FRAC_BITS];
		eb = operand_b[SIGN_POS-1:FRAC_BITS];
		sa = operand_a[SIGN_POS];
		sb = operand_b[SIGN_POS];
		maga = operand_a[SIGN_POS-1:0];
		magb = operand_b[SIGN_POS-1:0];
		// multiply path
		prod = {1'b1, operand_a[FRAC_BITS-1:0]} * {1'b1, operand_b[FRAC_BITS-1:0]};
		e_mul = EW'(ea) + EW'(eb) - EW'(BIAS) + EW'(prod[2*MANT_BITS-1]);
		f_mul = prod[2*MANT_BITS-1] ? prod[2*MANT_BITS-2 -: FRAC_BITS]
			: prod[2*MANT_BITS-3 -: FRAC_BITS];
		// add path
		if (maga >= magb) begin
			big = maga; sml = magb; sbig = sa;
		end else begin
			big = magb; sml = maga; sbig = sb;
		end
		ebig = big[SIGN_POS-1:FRAC_BITS];
		esmall = sml[SIGN_POS-1:FRAC_BITS];
		d = ebig - esmall;
		ma = {1'b0, 1'b1, big[FRAC_BITS-1:0], {GUARD{1'b0}}};
		mb = {1'b0, 1'b1, sml[FRAC_BITS-1:0], {GUARD{1'b0}}};
		mbs = mb >> d;
		if ((mbs << d) != mb)
			mbs[0] = 1'b1;
		sum = (sa == sb) ? ma + mbs : ma - mbs;
		p = '0;
		for (int i = 0; i < SUM_BITS; i++)
			if (sum[i])
				p = 4'(i);
		e_add = EW'(ebig) + EW'(p) - EW'(FRAC_BITS + GUARD);
		f_add = FRAC_BITS'((SUM_BITS+FRAC_BITS)'(sum) << FRAC_BITS >> p);
		// select
		if (ea == '1 || eb == '1)
			res = '{result: '1, status: ST_OVERFLOW};
		else if (opcode == OP_MUL) begin
			if (ea == '0 || eb == '0)
				res = '{result: '0, status: ST_NORMAL};
			else
				res = pack_res(sa ^ sb, e_mul, f_mul);
		end else if (ea == '0 && eb == '0)
			res = '{result: '0, status: ST_NORMAL};
		else if (ea == '0)
			res = '{result: operand_b, status: ST_NORMAL};
		else if (eb == '0)
			res = '{result: operand_a, status: ST_NORMAL};
		else if (sum == '0)
			res = '{result: '0, status: ST_NORMAL};
		else
			res = pack_res(sbig, e_add, f_add);
	end

endmodule

@@ sv/minifloat_add_multiply_unit.sv @@
// top level of the minifloat add / multiply unit
// an accepted request's result is captured in the output register and presented in the next cycle
// throughput: one request per cycle while the output is not stalled, set by the single datapath pass in mfau_core
// a full output register is freed in the same cycle it is taken
// reset: arst_n clears the output valid flag asynchronously
`include "assert_macros.svh"
module minifloat_add_multiply_unit
	import mfau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // operand_a, operand_b, zero fill
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // result, status, zero fill
);

	res_t res;
	res_t res_q;
	logic valid_q;

	mfau_core u_core (
		.opcode   (op_t'(s_tuser)),
		.operand_a(s_tdata[WORD_BITS-1:0]),
		.operand_b(s_tdata[2*WORD_BITS-1:WORD_BITS]),
		.res      (res)
	);

	assign s_tready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (s_tready)
			valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			res_q <= res;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.status, res_q.result};

	`ASSERT_NEXT(a_req_to_out, clk, arst_n, s_tvalid && s_tready, m_tvalid, "request lost")
	`ASSERT_IMPL(a_stall, clk, arst_n, m_tvalid && !m_tready, !s_tready, "overwrite on stall")
	`ASSERT_IMPL(a_ovf_ones, clk, arst_n, m_tvalid && res_q.status == ST_OVERFLOW,
		res_q.result == '1, "overflow not all ones")
	`ASSERT_IMPL(a_unf_zero, clk, arst_n, m_tvalid && res_q.status == ST_UNDERFLOW,
		res_q.result == '0, "underflow not zero")

endmodule

@@ bench/tb_top.sv @@
// testbench for the minifloat add / multiply unit: random and directed requests against a predictor
`timescale 1ns / 100ps
module tb_top;
	import mfau_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // operand_a, operand_b, zero fill
	logic        s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // result, status, zero fill

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [1:0]           stat;
	} outcome_t;

	outcome_t    pending_q[$];
	int          errors;
	int          sent;
	int          checked;
	int          cycles;
	int          n_ovf;
	int          n_unf;
	logic        stall_en;
	logic        long_gaps;

	localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
	localparam int CYCLE_LIMIT = 400000;

	minifloat_add_multiply_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int msb_index(logic [15:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 16; i++)
			if (v[i]) p = i;
		return p;
	endfunction

	function automatic outcome_t pack_float(logic sgn, int e, logic [FRAC_BITS-1:0] fr);
		outcome_t o;
		if (e > EXP_MAX) begin
			o.word = ALL_ONES;
			o.stat = ST_OVERFLOW;
		end else if (e < 1) begin
			o.word = '0;
			o.stat = ST_UNDERFLOW;
		end else begin
			o.word = {sgn, e[EXP_BITS-1:0], fr};
			o.stat = ST_NORMAL;
		end
		return o;
	endfunction

	function automatic outcome_t minifloat_calc(op_t op, logic [WORD_BITS-1:0] a,
			logic [WORD_BITS-1:0] b);
		outcome_t o;
		int ea, eb, e, d, p, ebig;
		logic [15:0] prod, ma, mb, sum;
		logic [SIGN_POS-1:0] maga, magb, big, sml;
		logic sbig;
		ea = int'(a[SIGN_POS-1:FRAC_BITS]);
		eb = int'(b[SIGN_POS-1:FRAC_BITS]);
		o.word = '0;
		o.stat = ST_NORMAL;
		if (ea == (1 << EXP_BITS) - 1 || eb == (1 << EXP_BITS) - 1) begin
			o.word = ALL_ONES;
			o.stat = ST_OVERFLOW;
		end else if (op == OP_MUL) begin
			if (ea != 0 && eb != 0) begin
				prod = 16'({1'b1, a[FRAC_BITS-1:0]}) * 16'({1'b1, b[FRAC_BITS-1:0]});
				e = ea + eb - BIAS;
				if (prod[2*FRAC_BITS+1]) begin
					e++;
					prod = prod >> (FRAC_BITS + 1);
				end else
					prod = prod >> FRAC_BITS;
				o = pack_float(a[SIGN_POS] ^ b[SIGN_POS], e, prod[FRAC_BITS-1:0]);
			end
		end else if (ea == 0 && eb == 0) begin
			o.word = '0;
		end else if (ea == 0 || eb == 0) begin
			o.word = (ea == 0) ? b : a;
		end else begin
			maga = a[SIGN_POS-1:0];
			magb = b[SIGN_POS-1:0];
			if (maga >= magb) begin
				big = maga; sml = magb; sbig = a[SIGN_POS];
			end else begin
				big = magb; sml = maga; sbig = b[SIGN_POS];
			end
			if (!(a[SIGN_POS] != b[SIGN_POS] && maga == magb)) begin
				ebig = int'(big[SIGN_POS-1:FRAC_BITS]);
				d = ebig - int'(sml[SIGN_POS-1:FRAC_BITS]);
				ma = 16'({1'b1, big[FRAC_BITS-1:0]}) << GUARD;
				mb = 16'({1'b1, sml[FRAC_BITS-1:0]}) << GUARD;
				if (d >= 16)
					mb = 16'd1;
				else if (d > 0)
					mb = (mb >> d) | 16'((mb & ((16'd1 << d) - 16'd1)) != 16'd0);
				sum = (a[SIGN_POS] == b[SIGN_POS]) ? ma + mb : ma - mb;
				if (sum != 0) begin
					p = msb_index(sum);
					e = ebig + p - (FRAC_BITS + GUARD);
					if (p > FRAC_BITS)
						sum = sum >> (p - FRAC_BITS);
					else
						sum = sum << (FRAC_BITS - p);
					o = pack_float(sbig, e, sum[FRAC_BITS-1:0]);
				end
			end
		end
		return o;
	endfunction

	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 2) == 0) begin
			n = long_gaps && $urandom_range(0, 15) == 0 ? $urandom_range(8, 30)
				: $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(op_t op, logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {8'd0, b, a};
		pending_q.push_back(minifloat_calc(op, a, b));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		if (stall_en)
			idle_gap();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [WORD_BITS-1:0] rand_float(bit edgy);
		logic [WORD_BITS-1:0] f;
		f = WORD_BITS'($urandom);
		if (edgy)
			case ($urandom_range(0, 4))
				0: f[SIGN_POS-1:FRAC_BITS] = '0;
				1: f[SIGN_POS-1:FRAC_BITS] = '1;
				2: f[SIGN_POS-1:FRAC_BITS] = EXP_BITS'($urandom_range(1, 3));
				3: f[SIGN_POS-1:FRAC_BITS] = EXP_BITS'($urandom_range(EXP_MAX - 2, EXP_MAX));
				default: f[SIGN_POS-1:FRAC_BITS] = EXP_BITS'($urandom_range(BIAS - 3, BIAS + 3));
			endcase
		return f;
	endfunction

	task automatic test_directed();
		stall_en = 1'b0;
		send_request(OP_ADD, 12'h000, 12'h000);
		send_request(OP_ADD, 12'h83F, 12'h3C0);
		send_request(OP_ADD, 12'h3C5, 12'h03F);
		send_request(OP_MUL, 12'h3C0, 12'h800);
		send_request(OP_MUL, 12'hFFF, 12'h3C0);
		send_request(OP_ADD, 12'h3C0, 12'h7C0);
		send_request(OP_ADD, 12'h3C7, 12'hBC7);
		send_request(OP_ADD, 12'h7BF, 12'h7BF);
		send_request(OP_MUL, 12'h7BF, 12'h7BF);
		send_request(OP_MUL, 12'h040, 12'h040);
		send_request(OP_ADD, 12'h041, 12'h840);
		send_request(OP_MUL, 12'hBFF, 12'h3FF);
		send_request(OP_ADD, 12'h780, 12'h041);
		send_request(OP_MUL, 12'h400, 12'hC00);
		send_request(OP_ADD, 12'h400, 12'h3FF);
		send_request(OP_ADD, 12'hFC0, 12'h000);
		drain();
	endtask

	task automatic test_random(int count, bit stalls);
		op_t op;
		stall_en = stalls;
		for (int i = 0; i < count; i++) begin
			op = op_t'($urandom_range(0, 1));
			send_request(op, rand_float(1'($urandom_range(0, 1))),
				rand_float(1'($urandom_range(0, 1))));
		end
		drain();
	endtask

	task automatic test_back_to_back();
		long_gaps = 1'b0;
		test_random(300, 1'b0);
		long_gaps = 1'b1;
	endtask

	// result checker
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_q.pop_front();
				checked++;
				if (want.stat == ST_OVERFLOW) n_ovf++;
				if (want.stat == ST_UNDERFLOW) n_unf++;
				if (m_tdata[WORD_BITS-1:0] !== want.word) begin
					$display("%0t result mismatch: expected %h actual %h", $time, want.word,
						m_tdata[WORD_BITS-1:0]);
					errors++;
				end
				if (m_tdata[WORD_BITS+1:WORD_BITS] !== want.stat) begin
					$display("%0t status mismatch: expected %0d actual %0d", $time, want.stat,
						m_tdata[WORD_BITS+1:WORD_BITS]);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!stall_en)
			m_tready <= 1'b1;
		else if ($urandom_range(0, 15) == 0)
			m_tready <= 1'b0;
		else if (!m_tready && $urandom_range(0, long_gaps ? 6 : 1) != 0)
			m_tready <= 1'b0;
		else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("minifloat_add_multiply_unit verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b1;
		stall_en = 1'b0;
		long_gaps = 1'b1;
		errors = 0;
		sent = 0;
		checked = 0;
		cycles = 0;
		n_ovf = 0;
		n_unf = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600, 1'b1);
		test_back_to_back();
		test_random(500, 1'b1);
		if (pending_q.size() != 0) begin
			$display("%0t %0d results never arrived", $time, pending_q.size());
			errors++;
		end
		$display("sent %0d requests, checked %0d results (%0d overflow, %0d underflow)",
			sent, checked, n_ovf, n_unf);
		$display("adds and multiplies over zero, top exponent, cancellation and range edges");
		if (errors == 0)
			$display("minifloat_add_multiply_unit verification clean");
		else
			$display("minifloat_add_multiply_unit verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+sv
sv/mfau_pkg.sv
sv/mfau_core.sv
sv/minifloat_add_multiply_unit.sv
bench/tb_top.sv
